### design/abe_pkg.sv
`timescale 1ns / 1ps
// abe_pkg: shared constants, mode codes and types for the allocation bitmap engine.
// No dependencies.

package abe_pkg;

	localparam int NUM_SECTORS_DEF = 4096;
	localparam int BLOCK_SECTORS   = 4;
	localparam int WORD_BITS       = 64;
	localparam int POS_W           = 6;
	localparam int IDX_W           = 12;
	localparam int MODE_W          = 3;
	localparam int INDEX_SPAN      = 4096;
	localparam logic [3:0] BLOCK_MASK = 4'hF;

	localparam logic [MODE_W-1:0] MODE_GET_SECTOR   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SET_SECTOR   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_GET_BLOCK    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SET_BLOCK    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ALLOC_SECTOR = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ALLOC_BLOCK  = 3'd5;

	// result of a first-free search over one map word
	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] pos;
	} abe_find_t;

endpackage

### design/abe_map_ram.sv
`timescale 1ns / 1ps
// abe_map_ram: single-port-write, registered-read memory of 64-bit map words.
// Depends on abe_pkg.

module abe_map_ram #(
	parameter int AW = 6
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [abe_pkg::WORD_BITS-1:0]  wdata,
	input  logic [AW-1:0]                  raddr,
	output logic [abe_pkg::WORD_BITS-1:0]  rdata
);

	logic [abe_pkg::WORD_BITS-1:0] mem [2**AW];
	logic [abe_pkg::WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/abe_first_free.sv
`timescale 1ns / 1ps
// abe_first_free: lowest free sector, or lowest free nibble-aligned block, in one map word.
// Depends on abe_pkg.

module abe_first_free (
	input  logic                          blocks,
	input  logic [abe_pkg::WORD_BITS-1:0] word,
	output abe_pkg::abe_find_t            find
);

	localparam int GROUPS = abe_pkg::WORD_BITS / 8;

	logic [abe_pkg::WORD_BITS-1:0] cand;
	logic [GROUPS-1:0]             grp_any;
	logic [3:0]                    g_res;
	logic [3:0]                    w_res;
	logic [7:0]                    grp_bits;

	// {hit, position} of lowest set bit of an 8-bit vector
	function automatic logic [3:0] ff8(input logic [7:0] v);
		logic [3:0] r;
		r = 4'd0;
		for (int k = 7; k >= 0; k--) begin
			if (v[k]) begin
				r = {1'b1, 3'(k)};
			end
		end
		return r;
	endfunction

	always_comb begin
		cand = '0;
		if (blocks) begin
			for (int j = 0; j < abe_pkg::WORD_BITS / abe_pkg::BLOCK_SECTORS; j++) begin
				cand[abe_pkg::BLOCK_SECTORS*j] = ~|word[abe_pkg::BLOCK_SECTORS*j +: 4];
			end
		end else begin
			cand = ~word;
		end
		for (int g = 0; g < GROUPS; g++) begin
			grp_any[g] = |cand[8*g +: 8];
		end
		g_res    = ff8(grp_any);
		grp_bits = cand[8*g_res[2:0] +: 8];
		w_res    = ff8(grp_bits);
		find.hit = g_res[3];
		find.pos = {g_res[2:0], w_res[2:0]};
	end

endmodule

### design/allocation_bitmap_engine.sv
`timescale 1ns / 1ps
// allocation_bitmap_engine: first-fit sector / block allocator over an in-use bitmap.
// Depends on abe_pkg, abe_map_ram, abe_first_free.
//
// Usage
//   Command channel: present mode, index and mark_used with start high; the beat
//   is taken at a rising edge where start is high and busy is low. One item is
//   worked on at a time; busy stays high until its result has been issued.
//   Result channel: done pulses for exactly one cycle with in_use, granted_index
//   and failed valid in that cycle. There is no back-pressure, the receiver must
//   take the beat when done is high.
//   Flow: gets, sets and allocations whose hint is free take one map-word read,
//   then sets and allocations modify and write the word back. An allocation that
//   falls through to the first-fit scan reads 64-bit map words in turn until a
//   free slot turns up or the reach ends: at most 64 words for sectors, and for
//   blocks 64 at the default size, 256 at most. busy is low while done is high,
//   so the next beat can be taken at the edge that takes the result. The scan
//   streams one word per cycle out of the map memory, so the memory read port
//   sets the rate. Reset: the map memory is swept to zero word by word after
//   arst_n releases, NUM_SECTORS/64 words (rounded up); busy is high throughout.

module allocation_bitmap_engine #(
	parameter int NUM_SECTORS = abe_pkg::NUM_SECTORS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [abe_pkg::MODE_W-1:0]    mode,
	input  logic [abe_pkg::IDX_W-1:0]     index,
	input  logic                          mark_used,
	output logic                          done,
	output logic                          in_use,
	output logic [abe_pkg::IDX_W-1:0]     granted_index,
	output logic                          failed
);

	localparam int MAP_WORDS  = (NUM_SECTORS + abe_pkg::WORD_BITS - 1) / abe_pkg::WORD_BITS;
	localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int NUM_BLOCKS = NUM_SECTORS / abe_pkg::BLOCK_SECTORS;
	// reach of the scan: only indices that granted_index can carry
	localparam int SREACH = (NUM_SECTORS < abe_pkg::INDEX_SPAN) ? NUM_SECTORS
	                                                             : abe_pkg::INDEX_SPAN;
	localparam int BREACH = (NUM_BLOCKS < abe_pkg::INDEX_SPAN) ? NUM_BLOCKS
	                                                            : abe_pkg::INDEX_SPAN;
	localparam int S_LAST = (SREACH + abe_pkg::WORD_BITS - 1) / abe_pkg::WORD_BITS - 1;
	localparam int B_LAST = (BREACH * abe_pkg::BLOCK_SECTORS + abe_pkg::WORD_BITS - 1)
	                        / abe_pkg::WORD_BITS - 1;
	localparam int SPW = AW + abe_pkg::POS_W;

	localparam logic [AW-1:0] S_LAST_W   = AW'(S_LAST);
	localparam logic [AW-1:0] B_LAST_W   = AW'(B_LAST);
	localparam logic [AW-1:0] MAP_LAST_W = AW'(MAP_WORDS - 1);
	localparam logic [31:0]   NSEC_C     = 32'(NUM_SECTORS);
	localparam logic [31:0]   NBLK_C     = 32'(NUM_BLOCKS);
	localparam logic [31:0]   SREACH_C   = 32'(SREACH);
	localparam logic [31:0]   BREACH_C   = 32'(BREACH);

	// sequencer states
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;
	localparam logic [1:0] ST_SCAN  = 2'd3;

	logic [1:0]                    state_q, state_d;
	logic [AW-1:0]                 clr_q;
	logic [abe_pkg::MODE_W-1:0]    mode_q;
	logic [abe_pkg::IDX_W-1:0]     idx_q;
	logic                          mark_q;
	logic                          blk_q;
	logic                          range_ok_q;
	logic [AW-1:0]                 word_q;
	logic [AW-1:0]                 scan_addr_q;
	logic [AW-1:0]                 data_word_q;

	logic                          done_q;
	logic                          in_use_q;
	logic [abe_pkg::IDX_W-1:0]     grant_q;
	logic                          fail_q;

	// memory port
	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [abe_pkg::WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]                 mem_raddr;
	logic [abe_pkg::WORD_BITS-1:0] mem_rdata;

	// command decode
	logic                          accept;
	logic [31:0]                   idx_ext;
	logic                          blk_in;
	logic                          range_ok_in;
	logic [31:0]                   word_in32;

	// look / scan datapath
	logic [abe_pkg::WORD_BITS-1:0] hint_mask;
	logic                          hint_used;
	abe_pkg::abe_find_t            find;
	logic [SPW-1:0]                scan_sp;
	logic [31:0]                   scan_sp32;
	logic [31:0]                   scan_idx32;
	logic                          scan_in_reach;
	logic [abe_pkg::WORD_BITS-1:0] scan_mask;
	logic [AW-1:0]                 scan_last;

	// result strobe
	logic                          fin;
	logic                          fin_use;
	logic [abe_pkg::IDX_W-1:0]     fin_grant;
	logic                          fin_fail;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign idx_ext = {{(32 - abe_pkg::IDX_W){1'b0}}, index};
	assign blk_in  = (mode == abe_pkg::MODE_GET_BLOCK) || (mode == abe_pkg::MODE_SET_BLOCK)
	              || (mode == abe_pkg::MODE_ALLOC_BLOCK);
	assign range_ok_in = blk_in ? (idx_ext < NBLK_C) : (idx_ext < NSEC_C);
	// block b lives in word b/16, sector s in word s/64
	assign word_in32   = blk_in ? (idx_ext >> 4) : (idx_ext >> abe_pkg::POS_W);

	// bits that the target sector or block covers in its word
	assign hint_mask = blk_q
		? ({{(abe_pkg::WORD_BITS - 4){1'b0}}, abe_pkg::BLOCK_MASK} << {idx_q[3:0], 2'b00})
		: ({{(abe_pkg::WORD_BITS - 1){1'b0}}, 1'b1} << idx_q[abe_pkg::POS_W-1:0]);
	assign hint_used = |(mem_rdata & hint_mask);

	abe_first_free u_find (
		.blocks (blk_q),
		.word   (mem_rdata),
		.find   (find)
	);

	assign scan_sp       = {data_word_q, find.pos};
	assign scan_sp32     = {{(32 - SPW){1'b0}}, scan_sp};
	assign scan_idx32    = blk_q ? (scan_sp32 >> 2) : scan_sp32;
	assign scan_in_reach = blk_q ? (scan_idx32 < BREACH_C) : (scan_idx32 < SREACH_C);
	assign scan_mask     = blk_q
		? ({{(abe_pkg::WORD_BITS - 4){1'b0}}, abe_pkg::BLOCK_MASK} << find.pos)
		: ({{(abe_pkg::WORD_BITS - 1){1'b0}}, 1'b1} << find.pos);
	assign scan_last     = blk_q ? B_LAST_W : S_LAST_W;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = word_q;
		mem_wdata = mem_rdata;
		mem_raddr = scan_addr_q;
		fin       = 1'b0;
		fin_use   = 1'b0;
		fin_grant = '0;
		fin_fail  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == MAP_LAST_W) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// target word read straight off the command beat
				mem_raddr = word_in32[AW-1:0];
				if (accept) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				mem_raddr = '0;
				case (mode_q)
					abe_pkg::MODE_GET_SECTOR, abe_pkg::MODE_GET_BLOCK: begin
						fin      = 1'b1;
						fin_use  = range_ok_q && hint_used;
						fin_fail = !range_ok_q;
					end
					abe_pkg::MODE_SET_SECTOR, abe_pkg::MODE_SET_BLOCK: begin
						fin       = 1'b1;
						fin_fail  = !range_ok_q;
						mem_we    = range_ok_q;
						mem_wdata = mark_q ? (mem_rdata | hint_mask) : (mem_rdata & ~hint_mask);
					end
					abe_pkg::MODE_ALLOC_SECTOR, abe_pkg::MODE_ALLOC_BLOCK: begin
						if (range_ok_q && !hint_used) begin
							fin       = 1'b1;
							fin_grant = idx_q;
							mem_we    = 1'b1;
							mem_wdata = mem_rdata | hint_mask;
						end else begin
							// word 0 is read now, the scan starts next cycle
							state_d = ST_SCAN;
						end
					end
					default: begin
						fin      = 1'b1;
						fin_fail = 1'b1;
					end
				endcase
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (find.hit) begin
					fin = 1'b1;
					if (scan_in_reach) begin
						fin_grant = scan_idx32[abe_pkg::IDX_W-1:0];
						mem_we    = 1'b1;
						mem_waddr = data_word_q;
						mem_wdata = mem_rdata | scan_mask;
					end else begin
						fin_fail = 1'b1;
					end
				end else if (data_word_q == scan_last) begin
					fin      = 1'b1;
					fin_fail = 1'b1;
				end
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	abe_map_ram #(
		.AW (AW)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			scan_addr_q <= '0;
			data_word_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_LOOK) begin
				scan_addr_q <= AW'(1);
				data_word_q <= '0;
			end else if (state_q == ST_SCAN) begin
				scan_addr_q <= scan_addr_q + 1'b1;
				data_word_q <= scan_addr_q;
			end
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= mode;
			idx_q      <= index;
			mark_q     <= mark_used;
			blk_q      <= blk_in;
			range_ok_q <= range_ok_in;
			word_q     <= word_in32[AW-1:0];
		end
		if (fin) begin
			in_use_q <= fin_use;
			grant_q  <= fin_grant;
			fail_q   <= fin_fail;
		end
	end

	assign done          = done_q;
	assign in_use        = in_use_q;
	assign granted_index = grant_q;
	assign failed        = fail_q;

endmodule

### design/abe_checker.sv
`timescale 1ns / 1ps
// abe_checker: port-level checks on the allocation bitmap engine, bound to the top level.
// Depends on abe_pkg and allocation_bitmap_engine.

module abe_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic                       in_use,
	input logic [abe_pkg::IDX_W-1:0]  granted_index,
	input logic                       failed
);

	// an accepted beat makes busy rise in the following cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted command");

	// a result only ever closes a piece of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// one item at a time, so strobes never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe on two cycles in a row");

	// a failed item reports nothing in use and grants nothing
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && failed |-> !in_use && (granted_index == '0))
		else $error("failed result carries in_use or a grant");

endmodule

bind allocation_bitmap_engine abe_checker u_abe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.in_use        (in_use),
	.granted_index (granted_index),
	.failed        (failed)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for allocation_bitmap_engine, default map size.
// Depends on abe_pkg and allocation_bitmap_engine; the scoreboard keeps its own in-use map.

module tb_top;

	localparam int IDX_W   = abe_pkg::IDX_W;
	localparam int SECTORS = abe_pkg::NUM_SECTORS_DEF;
	localparam int BLOCKS  = SECTORS / abe_pkg::BLOCK_SECTORS;

	// spare mode codes, answered with a plain failure
	localparam logic [abe_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [abe_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

	localparam int RANDOM_ITEMS = 660;
	// blocks filled from the bottom so that scans cross several map words
	localparam int FILL_BLOCKS  = 128;
	// a scan reads at most 64 map words, so this covers any stray result comfortably
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic [abe_pkg::MODE_W-1:0] mode;
		logic [IDX_W-1:0]           index;
		logic                       mark;
	} command_t;

	typedef struct packed {
		logic             in_use;
		logic [IDX_W-1:0] granted;
		logic             failed;
	} answer_t;

	typedef struct packed {
		command_t cmd;
		answer_t  ans;
	} due_t;

	// Scoreboard: mirrors the in-use map, works out each answer as the command
	// beat is taken and holds it until the matching result beat turns up.
	class bitmap_scoreboard;
		localparam int MAP_SECTORS  = abe_pkg::NUM_SECTORS_DEF;
		localparam int MAP_BLOCKS   = MAP_SECTORS / abe_pkg::BLOCK_SECTORS;
		localparam int SECTOR_REACH = (MAP_SECTORS < abe_pkg::INDEX_SPAN) ?
			MAP_SECTORS : abe_pkg::INDEX_SPAN;
		localparam int BLOCK_REACH  = (MAP_BLOCKS < abe_pkg::INDEX_SPAN) ?
			MAP_BLOCKS : abe_pkg::INDEX_SPAN;

		bit          used_map [MAP_SECTORS];
		due_t        answers_due [$];
		int unsigned mismatch_count;

		function new();
			foreach (used_map[i])
				used_map[i] = 1'b0;
			mismatch_count = 0;
		endfunction

		function bit block_taken(input int unsigned b);
			bit any;
			any = 1'b0;
			for (int k = 0; k < abe_pkg::BLOCK_SECTORS; k++)
				any |= used_map[b * abe_pkg::BLOCK_SECTORS + k];
			return any;
		endfunction

		function void mark_block(input int unsigned b, input bit v);
			for (int k = 0; k < abe_pkg::BLOCK_SECTORS; k++)
				used_map[b * abe_pkg::BLOCK_SECTORS + k] = v;
		endfunction

		// answer of one command, applying its effect on the map
		function answer_t run_allocator(input command_t c);
			answer_t     r;
			int unsigned idx;
			int unsigned i;
			r = '0;
			idx = c.index;
			case (c.mode)
				abe_pkg::MODE_GET_SECTOR: begin
					if (idx < MAP_SECTORS)
						r.in_use = used_map[idx];
					else
						r.failed = 1'b1;
				end
				abe_pkg::MODE_SET_SECTOR: begin
					if (idx < MAP_SECTORS)
						used_map[idx] = c.mark;
					else
						r.failed = 1'b1;
				end
				abe_pkg::MODE_GET_BLOCK: begin
					if (idx < MAP_BLOCKS)
						r.in_use = block_taken(idx);
					else
						r.failed = 1'b1;
				end
				abe_pkg::MODE_SET_BLOCK: begin
					if (idx < MAP_BLOCKS)
						mark_block(idx, c.mark);
					else
						r.failed = 1'b1;
				end
				abe_pkg::MODE_ALLOC_SECTOR: begin
					if (idx < MAP_SECTORS && !used_map[idx]) begin
						used_map[idx] = 1'b1;
						r.granted = c.index;
					end else begin
						// hint taken or out of range: first fit from zero
						r.failed = 1'b1;
						for (i = 0; i < SECTOR_REACH && r.failed; i++) begin
							if (!used_map[i]) begin
								used_map[i] = 1'b1;
								r.granted = i[IDX_W-1:0];
								r.failed = 1'b0;
							end
						end
					end
				end
				abe_pkg::MODE_ALLOC_BLOCK: begin
					if (idx < MAP_BLOCKS && !block_taken(idx)) begin
						mark_block(idx, 1'b1);
						r.granted = c.index;
					end else begin
						r.failed = 1'b1;
						for (i = 0; i < BLOCK_REACH && r.failed; i++) begin
							if (!block_taken(i)) begin
								mark_block(i, 1'b1);
								r.granted = i[IDX_W-1:0];
								r.failed = 1'b0;
							end
						end
					end
				end
				default: r.failed = 1'b1;
			endcase
			return r;
		endfunction

		task note_command(input command_t c);
			due_t d;
			d.cmd = c;
			d.ans = run_allocator(c);
			answers_due.push_back(d);
		endtask

		task report_mismatch(input string what);
			$display("MISMATCH @%0t: %s", $time, what);
			mismatch_count++;
		endtask

		task check_result(input answer_t got);
			due_t  head;
			string tag;
			if (answers_due.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing outstanding (%0b/%0d/%0b)",
					got.in_use, got.granted, got.failed));
			end else begin
				head = answers_due.pop_front();
				tag = $sformatf("mode %0d index %0d mark %0b", head.cmd.mode, head.cmd.index,
					head.cmd.mark);
				if (got.in_use !== head.ans.in_use)
					report_mismatch($sformatf("%s: in_use %0b, want %0b", tag, got.in_use,
						head.ans.in_use));
				if (got.granted !== head.ans.granted)
					report_mismatch($sformatf("%s: granted_index %0d, want %0d", tag,
						got.granted, head.ans.granted));
				if (got.failed !== head.ans.failed)
					report_mismatch($sformatf("%s: failed %0b, want %0b", tag, got.failed,
						head.ans.failed));
			end
		endtask

		function int unsigned pending();
			return answers_due.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [abe_pkg::MODE_W-1:0] mode;
	logic [IDX_W-1:0]           index;
	logic                       mark_used;
	logic                       done;
	logic                       in_use;
	logic [IDX_W-1:0]           granted_index;
	logic                       failed;

	bitmap_scoreboard sb;
	bit               steady;	// no idle gaps while set

	allocation_bitmap_engine u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.index         (index),
		.mark_used     (mark_used),
		.done          (done),
		.in_use        (in_use),
		.granted_index (granted_index),
		.failed        (failed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result beats cannot be held off: take every one that done marks.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result({in_use, granted_index, failed});
	end

	function automatic command_t make_command(input logic [abe_pkg::MODE_W-1:0] m,
			input int unsigned idx, input bit mk);
		command_t c;
		c.mode  = m;
		c.index = idx[IDX_W-1:0];
		c.mark  = mk;
		return c;
	endfunction

	// sector indices: half near the bottom where first fit lands, half anywhere
	function automatic int unsigned pick_sector();
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, 255);
		return $urandom_range(0, SECTORS - 1);
	endfunction

	// block indices: mostly in range, the rest anywhere in the 12-bit field
	function automatic int unsigned pick_block();
		if ($urandom_range(0, 3) != 0)
			return $urandom_range(0, BLOCKS - 1);
		return $urandom_range(0, (1 << IDX_W) - 1);
	endfunction

	// allocation hints: low ones tend to be taken and force the scan
	function automatic int unsigned pick_hint(input int unsigned span);
		if ($urandom_range(0, 9) < 4)
			return $urandom_range(0, 63);
		return $urandom_range(0, span - 1);
	endfunction

	function automatic command_t random_command(input int unsigned mark_pct);
		int unsigned pick;
		bit          mk;
		pick = $urandom_range(0, 99);
		mk = ($urandom_range(0, 99) < mark_pct);
		if (pick < 3)
			return make_command(pick[0] ? MODE_SPARE_7 : MODE_SPARE_6,
				$urandom_range(0, (1 << IDX_W) - 1), mk);
		if (pick < 15)
			return make_command(abe_pkg::MODE_GET_SECTOR, pick_sector(), mk);
		if (pick < 27)
			return make_command(abe_pkg::MODE_SET_SECTOR, pick_sector(), mk);
		if (pick < 37)
			return make_command(abe_pkg::MODE_GET_BLOCK, pick_block(), mk);
		if (pick < 47)
			return make_command(abe_pkg::MODE_SET_BLOCK, pick_block(), mk);
		if (pick < 73)
			return make_command(abe_pkg::MODE_ALLOC_SECTOR, pick_hint(1 << IDX_W), mk);
		return make_command(abe_pkg::MODE_ALLOC_BLOCK, pick_hint(1 << IDX_W), mk);
	endfunction

	// Drive one command beat. Called at a falling edge, returns at a falling edge.
	// start stays high across back-to-back beats, so it is only lowered for a gap.
	task automatic send_command(input command_t c);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start     <= 1'b1;
		mode      <= c.mode;
		index     <= c.index;
		mark_used <= c.mark;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(c);
		@(negedge clk);
	endtask

	// Fill the bottom of the map so taken hints push the scans across several
	// words, open single holes at the top of the filled part, then scatter holes.
	task automatic fill_low_map();
		int unsigned b;
		for (b = 0; b < FILL_BLOCKS; b++)
			send_command(make_command(abe_pkg::MODE_SET_BLOCK, b, 1'b1));
		send_command(make_command(abe_pkg::MODE_ALLOC_SECTOR,
			$urandom_range(0, FILL_BLOCKS * abe_pkg::BLOCK_SECTORS - 1), 1'b0));
		send_command(make_command(abe_pkg::MODE_ALLOC_BLOCK, $urandom_range(0, FILL_BLOCKS - 1),
			1'b1));
		send_command(make_command(abe_pkg::MODE_ALLOC_BLOCK, (1 << IDX_W) - 1, 1'b0));
		send_command(make_command(abe_pkg::MODE_SET_SECTOR,
			FILL_BLOCKS * abe_pkg::BLOCK_SECTORS - 1, 1'b0));
		send_command(make_command(abe_pkg::MODE_ALLOC_BLOCK, 0, 1'b0));
		send_command(make_command(abe_pkg::MODE_ALLOC_SECTOR, 0, 1'b0));
		send_command(make_command(abe_pkg::MODE_SET_BLOCK, FILL_BLOCKS - 1, 1'b0));
		send_command(make_command(abe_pkg::MODE_ALLOC_BLOCK, 0, 1'b1));
		// a handful of random holes for the traffic that follows
		repeat (12) begin
			send_command(make_command(abe_pkg::MODE_SET_SECTOR, pick_sector(), 1'b0));
			send_command(make_command(abe_pkg::MODE_SET_BLOCK, $urandom_range(0, BLOCKS - 1),
				1'b0));
		end
	endtask

	initial begin
		int unsigned sent;
		int unsigned run_len;
		int unsigned mark_pct;
		bit          filled;

		sb = new();
		steady    = 1'b0;
		arst_n    = 1'b0;
		start     = 1'b0;
		mode      = abe_pkg::MODE_GET_SECTOR;
		index     = '0;
		mark_used = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Directed beats: field extremes, every mode, out-of-range index and hint,
		// taken hint falling through to the scan, and both spare modes.
		send_command(make_command(abe_pkg::MODE_GET_SECTOR, 0, 1'b0));
		send_command(make_command(abe_pkg::MODE_GET_SECTOR, SECTORS - 1, 1'b1));
		send_command(make_command(abe_pkg::MODE_SET_SECTOR, SECTORS - 1, 1'b1));
		send_command(make_command(abe_pkg::MODE_GET_SECTOR, SECTORS - 1, 1'b0));
		send_command(make_command(abe_pkg::MODE_GET_BLOCK, BLOCKS - 1, 1'b0));
		send_command(make_command(abe_pkg::MODE_GET_BLOCK, BLOCKS, 1'b0));
		send_command(make_command(abe_pkg::MODE_SET_BLOCK, (1 << IDX_W) - 1, 1'b1));
		send_command(make_command(abe_pkg::MODE_SET_BLOCK, 0, 1'b1));
		send_command(make_command(abe_pkg::MODE_GET_SECTOR, 3, 1'b0));
		send_command(make_command(abe_pkg::MODE_ALLOC_SECTOR, 2, 1'b0));
		send_command(make_command(abe_pkg::MODE_ALLOC_SECTOR, 100, 1'b1));
		send_command(make_command(abe_pkg::MODE_ALLOC_BLOCK, 0, 1'b0));
		send_command(make_command(abe_pkg::MODE_ALLOC_BLOCK, (1 << IDX_W) - 1, 1'b1));
		send_command(make_command(abe_pkg::MODE_ALLOC_BLOCK, 500, 1'b0));
		send_command(make_command(abe_pkg::MODE_SET_BLOCK, 0, 1'b0));
		send_command(make_command(abe_pkg::MODE_ALLOC_SECTOR, SECTORS - 1, 1'b0));
		send_command(make_command(MODE_SPARE_6, (1 << IDX_W) - 1, 1'b1));
		send_command(make_command(MODE_SPARE_7, 0, 1'b0));
		send_command(make_command(abe_pkg::MODE_SET_SECTOR, SECTORS - 1, 1'b0));
		send_command(make_command(abe_pkg::MODE_GET_SECTOR, SECTORS - 1, 1'b1));
		send_command(make_command(abe_pkg::MODE_GET_BLOCK, (1 << IDX_W) - 1, 1'b1));
		send_command(make_command(abe_pkg::MODE_SET_SECTOR, 0, 1'b1));

		// Random traffic in runs; each run has its own idling and mark bias.
		// Halfway through, the bottom of the map is filled to lengthen the scans.
		sent = 0;
		filled = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			run_len  = $urandom_range(10, 60);
			steady   = ($urandom_range(0, 3) == 0);
			mark_pct = $urandom_range(0, 4) * 25;
			if (!filled && sent >= RANDOM_ITEMS / 2) begin
				fill_low_map();
				filled = 1'b1;
			end
			repeat (run_len) begin
				send_command(random_command(mark_pct));
				sent++;
			end
		end
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0)
			$display("allocation_bitmap_engine verification clean");
		else
			$display("allocation_bitmap_engine verification failed");
		$finish;
	end

	// Run limit: many times the slowest correct run (about 0.25 ms).
	initial begin
		#5000000;
		$display("allocation_bitmap_engine verification failed");
		$finish;
	end

endmodule
